/* sv/b64e_pkg.sv */
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies; used by every other file of the block.
`default_nettype none

package b64e_pkg;

    localparam logic [15:0] DEF_OUTPUT_LIMIT = 16'hFFFF;
    localparam int          DEF_QUEUE_DEPTH  = 4;
    localparam logic [6:0]  PAD_CHAR         = 7'd61;   // '='

    // Work for the back end: up to two sextets from one request plus end flag.
    typedef struct packed {
        logic [5:0] sext0;
        logic [5:0] sext1;
        logic [1:0] nsext;
        logic       eom;
    } cmd_t;

    // Result fields as held in the output register.
    typedef struct packed {
        logic [6:0]  char_code;
        logic        char_valid;
        logic        message_done;
        logic        overflow_error;
        logic [15:0] char_count;
        logic        last_of_run;
    } result_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 7'd65 + {1'b0, v};
            [6'd26:6'd51]: c = 7'd71 + {1'b0, v};
            [6'd52:6'd61]: c = {1'b0, v} - 7'd4;
            6'd62:         c = 7'd43;
            default:       c = 7'd47;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/base64_stream_encoder_unit.sv */
// Top level of the streaming base64 encoder: front end, work queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//  port group   dir  handshake            payload
//  input        in   in_valid/in_ready    data_byte, byte_present, end_of_message
//  result       out  out_valid/out_ready  char_code, char_valid, message_done,
//                                         overflow_error, char_count, last_of_run
//  config       in   cfg_write_en         cfg_write_data (output_limit)
//
// The front end takes one request per cycle while the queue has room; the back end
// emits one result per cycle unless out_ready stalls it. A queued request that is not
// dropped causes one to four results, and the back end takes no new request until the
// last of them is emitted. Requests dropped after an overflow give no result. Reset is
// asynchronous and sets output_limit to 65535. QUEUE_DEPTH requests buffer the front
// end against output stalls.
`default_nettype none

module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = b64e_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       char_code,
    output logic             char_valid,
    output logic             message_done,
    output logic             overflow_error,
    output logic [15:0]      char_count,
    output logic             last_of_run
);

    logic              push_valid, push_ready, head_valid, pop;
    b64e_pkg::cmd_t    push_data, head;
    b64e_pkg::result_t result;

    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (pop),
        .pop_data   (head)
    );

    b64e_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result         (result)
    );

    assign char_code      = result.char_code;
    assign char_valid     = result.char_valid;
    assign message_done   = result.message_done;
    assign overflow_error = result.overflow_error;
    assign char_count     = result.char_count;
    assign last_of_run    = result.last_of_run;

endmodule

`default_nettype wire

/* sv/b64e_front.sv */
// Front end: accepts requests, packs bytes into sextets, queues work for the back end.
// Depends on b64e_pkg (cmd_t).
`default_nettype none

module b64e_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     data_byte,
    input  wire logic           byte_present,
    input  wire logic           end_of_message,
    output logic                push_valid,
    input  wire logic           push_ready,
    output b64e_pkg::cmd_t      push_data
);

    logic [3:0] acc_reg, acc_next;
    logic [2:0] rem_reg, rem_next;
    logic       accept;

    // Empty requests carry no work; they never wait on the queue beyond its full flag.
    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = in_valid && (byte_present || end_of_message);

    always_comb
    begin
        b64e_pkg::cmd_t c;
        logic [3:0] a;
        logic [2:0] r;
        c = '0;
        a = acc_reg;
        r = rem_reg;
        if (byte_present)
        begin
            case (rem_reg)
                3'd0:
                begin
                    c.sext0 = data_byte[7:2];
                    c.nsext = 2'd1;
                    a = {2'b00, data_byte[1:0]};
                    r = 3'd2;
                end
                3'd2:
                begin
                    c.sext0 = {acc_reg[1:0], data_byte[7:4]};
                    c.nsext = 2'd1;
                    a = data_byte[3:0];
                    r = 3'd4;
                end
                default:
                begin
                    c.sext0 = {acc_reg, data_byte[7:6]};
                    c.sext1 = data_byte[5:0];
                    c.nsext = 2'd2;
                    a = 4'd0;
                    r = 3'd0;
                end
            endcase
        end
        // flush leftover bits, zero padded, as one more sextet
        if (end_of_message && r != 3'd0)
        begin
            if (c.nsext == 2'd0)
                c.sext0 = (r == 3'd2) ? {a[1:0], 4'b0000} : {a, 2'b00};
            else
                c.sext1 = (r == 3'd2) ? {a[1:0], 4'b0000} : {a, 2'b00};
            c.nsext = c.nsext + 2'd1;
        end
        c.eom = end_of_message;
        push_data = c;
        if (end_of_message)
        begin
            acc_next = 4'd0;
            rem_next = 3'd0;
        end
        else
        begin
            acc_next = a;
            rem_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 4'd0;
            rem_reg <= 3'd0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* sv/b64e_queue.sv */
// Small FIFO of back-end work between front and back.
// Depends on b64e_pkg (cmd_t).
`default_nettype none

module b64e_queue #(
    parameter int DEPTH = b64e_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire b64e_pkg::cmd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop,
    output b64e_pkg::cmd_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* sv/b64e_back.sv */
// Back end: room checks, character and pad emission, message count, output register.
// Depends on b64e_pkg (cmd_t, result_t, b64_char, constants).
`default_nettype none

module b64e_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write_en,
    input  wire logic [15:0]    cfg_write_data,
    input  wire logic           head_valid,
    input  wire b64e_pkg::cmd_t head,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output b64e_pkg::result_t   result
);

    logic [15:0] limit_reg;
    logic [15:0] count_reg, count_next;
    logic        aborted_reg, aborted_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    b64e_pkg::result_t res_reg, res_next;

    logic        slot_free, go, emit;
    logic [16:0] count_p1;
    logic        room_fail, term_fail, has_sext, need_pad, more;
    logic [1:0]  idx_inc;
    logic [5:0]  sext_sel;

    assign slot_free = !out_valid_reg || out_ready;
    // dropped requests need no output slot
    assign go        = head_valid && (aborted_reg || slot_free);
    assign count_p1  = {1'b0, count_reg} + 17'd1;
    assign room_fail = count_p1 >= {1'b0, limit_reg};
    assign term_fail = count_reg >= limit_reg;
    assign has_sext  = idx_reg < head.nsext;
    assign need_pad  = head.eom && (count_reg[1:0] != 2'd0);
    assign idx_inc   = idx_reg + 2'd1;
    assign sext_sel  = idx_reg[0] ? head.sext1 : head.sext0;
    // after this char: another sextet, or padding still owed
    assign more      = (idx_inc < head.nsext) || (head.eom && (count_p1[1:0] != 2'd0));

    always_comb
    begin
        count_next     = count_reg;
        aborted_next   = aborted_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (go)
        begin
            if (aborted_reg)
            begin
                pop = 1'b1;
                if (head.eom)
                begin
                    aborted_next = 1'b0;
                    count_next   = 16'd0;
                end
            end
            else if (has_sext || need_pad)
            begin
                emit = 1'b1;
                if (room_fail)
                begin
                    res_next     = '{char_code: 7'd0, char_valid: 1'b0, message_done: 1'b1,
                                     overflow_error: 1'b1, char_count: count_reg,
                                     last_of_run: 1'b1};
                    pop          = 1'b1;
                    idx_next     = 2'd0;
                    aborted_next = !head.eom;
                    if (head.eom)
                        count_next = 16'd0;
                end
                else
                begin
                    res_next = '{char_code: has_sext ? b64e_pkg::b64_char(sext_sel)
                                                     : b64e_pkg::PAD_CHAR,
                                 char_valid: 1'b1, message_done: head.eom && !more,
                                 overflow_error: 1'b0, char_count: count_p1[15:0],
                                 last_of_run: !more};
                    if (more)
                    begin
                        count_next = count_p1[15:0];
                        if (has_sext)
                            idx_next = idx_inc;
                    end
                    else
                    begin
                        pop        = 1'b1;
                        idx_next   = 2'd0;
                        count_next = head.eom ? 16'd0 : count_p1[15:0];
                    end
                end
            end
            else
            begin
                // end request with nothing to emit: terminator check only
                emit         = 1'b1;
                res_next     = '{char_code: 7'd0, char_valid: 1'b0, message_done: 1'b1,
                                 overflow_error: term_fail, char_count: count_reg,
                                 last_of_run: 1'b1};
                pop          = 1'b1;
                idx_next     = 2'd0;
                count_next   = 16'd0;
                aborted_next = 1'b0;
            end
        end
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= b64e_pkg::DEF_OUTPUT_LIMIT;
            count_reg     <= 16'd0;
            aborted_reg   <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                limit_reg <= cfg_write_data;
            count_reg     <= count_next;
            aborted_reg   <= aborted_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

`ifndef NO_ASSERTIONS
    // index rests at 2 while pads follow the second sextet
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 2'd2)
        else $error("sextet index out of range");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.overflow_error |->
            res_reg.message_done && !res_reg.char_valid && res_reg.last_of_run)
        else $error("malformed error result");

    a_done_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.char_valid && res_reg.message_done |->
            res_reg.char_count[1:0] == 2'd0)
        else $error("message ended off a four-char boundary");

    a_abort_silent: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg |-> !emit)
        else $error("result emitted while message aborted");

    a_mid_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
        go && !pop |=> head_valid)
        else $error("queue head lost mid run");
`endif

endmodule

`default_nettype wire
